// ----- src/gcc_pkg.sv -----
// ----------------------------------------------------------------------------
// gcc_pkg: shared constants, types and tables for the great-circle course block
// Holds the fixed field widths, the CORDIC arctangent table in binary-angle
// units and the remainder table used by the degree-to-turn conversion.
// ----------------------------------------------------------------------------
package gcc_pkg;

   localparam int ANGLE_FRAC_BITS_DEF = 16;
   localparam int TRIG_ITERATIONS_DEF = 24;

   localparam int LON_W    = 25;
   localparam int LAT_W    = 24;
   localparam int COURSE_W = 25;
   localparam int DL_W     = 26;   // longitude difference, exact
   localparam int LANES    = 3;    // longitude difference and two latitudes

   // degree-to-turn division by 45 through a reciprocal multiply
   localparam int OFS_W       = 27;
   localparam int RECIP_W     = 28;
   localparam int PROD_W      = OFS_W + RECIP_W;
   localparam int RECIP_SHIFT = 33;
   localparam int QUO_W       = PROD_W - RECIP_SHIFT;
   localparam int REM_W       = 7;
   localparam int DIV_BASE    = 45;
   localparam int IDX_W       = $clog2(DIV_BASE);
   localparam int QUO_BIAS    = 1 << 20;
   localparam int ROUND_BIAS  = 22;
   localparam logic [RECIP_W-1:0] RECIP      = 28'd190887435;
   localparam logic [OFS_W-1:0]   DIV_OFFSET = 27'd47185920;

   localparam int TURN_W    = 32;
   localparam int ROT_W     = 34;
   localparam int VEC_W     = 36;
   localparam int UNIT_FRAC = 30;
   localparam logic signed [ROT_W-1:0] INV_GAIN = 34'sd652032874;

   localparam int QUEUE_DEPTH = 4;

   localparam logic [TURN_W-1:0] ATAN_TURN [32] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756, 32'd42667331,
      32'd21354465, 32'd10679838, 32'd5340245, 32'd2670163, 32'd1335087,
      32'd667544, 32'd333772, 32'd166886, 32'd83443, 32'd41722, 32'd20861,
      32'd10430, 32'd5215, 32'd2608, 32'd1304, 32'd652, 32'd326, 32'd163,
      32'd81, 32'd41, 32'd20, 32'd10, 32'd5, 32'd3, 32'd1, 32'd1, 32'd0
   };

   typedef struct packed {
      logic [TURN_W-1:0] dlon;
      logic [TURN_W-1:0] lat1;
      logic [TURN_W-1:0] lat2;
   } turns_type;

   typedef logic [TURN_W-1:0] frac_tab_type [DIV_BASE];

   // turn contribution of a remainder r: floor((r * 2^shift + 22) / 45)
   function automatic frac_tab_type frac_table(input int shift);
      frac_tab_type t;
      longint       num;
      for (int r = 0; r < DIV_BASE; r++) begin
         num  = (longint'(r) << shift) + ROUND_BIAS;
         t[r] = TURN_W'(num / DIV_BASE);
      end
      return t;
   endfunction

endpackage

// ----- src/gcc_if.sv -----
// ----------------------------------------------------------------------------
// gcc_if: request and response channels of the great-circle course block
// Valid/ready channels; a transaction moves at a clock edge with both high.
// ----------------------------------------------------------------------------
interface gcc_req_if import gcc_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic signed [LON_W-1:0] start_lon;
   logic signed [LAT_W-1:0] start_lat;
   logic signed [LON_W-1:0] end_lon;
   logic signed [LAT_W-1:0] end_lat;

   modport source (output valid, start_lon, start_lat, end_lon, end_lat, input ready);
   modport sink   (input valid, start_lon, start_lat, end_lon, end_lat, output ready);
endinterface

interface gcc_rsp_if import gcc_pkg::*;;
   logic                       valid;
   logic                       ready;
   logic signed [COURSE_W-1:0] course_at_start;
   logic signed [COURSE_W-1:0] course_at_end;

   modport source (output valid, course_at_start, course_at_end, input ready);
   modport sink   (input valid, course_at_start, course_at_end, output ready);
endinterface

// ----- src/great_circle_course.sv -----
// A request passes the front-end stages, the queue and the back-end pipeline,
// where the two CORDIC chains make up most of the stages, to the response.
// Throughput: one transaction per cycle while responses are taken, limited by no shared unit.
// Reset: synchronous, active high; clears the valid bits and queue pointers,
// leaving the datapath registers as they are.
// ----------------------------------------------------------------------------
// great_circle_course: initial and final great-circle course of a point pair
// Front end converts degrees to binary angles, a four-entry queue decouples it
// from the back end, which runs sine/cosine, products, atan2 and the degree
// conversion in a stall-as-one pipeline ending in the response register.
// ----------------------------------------------------------------------------
module great_circle_course import gcc_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   gcc_req_if.sink   req_chan,
   gcc_rsp_if.source rsp_chan
);

   // front end to queue
   logic      push;
   logic      full;
   turns_type push_data;

   // queue to back end
   logic      pop;
   logic      empty;
   turns_type head;

   // Accept a request whenever the converted item ahead can move on into the
   // queue; a waiting response only stalls the back end.
   gcc_front #(.ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .full      (full),
      .push      (push),
      .push_data (push_data)
   );

   // Absorb the back end's stalls for a few transactions.
   gcc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (full),
      .pop       (pop),
      .pop_data  (head),
      .empty     (empty)
   );

   // Drain the queue one transaction per cycle while the response moves.
   gcc_back #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .TRIG_ITERATIONS (TRIG_ITERATIONS)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .empty (empty),
      .pop   (pop),
      .rsp   (rsp_chan)
   );

endmodule

// ----- src/gcc_front.sv -----
// ----------------------------------------------------------------------------
// gcc_front: request intake and degree-to-turn conversion
// Two stages: reciprocal multiply by 1/45, then correction and table lookup.
// ----------------------------------------------------------------------------
module gcc_front import gcc_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   gcc_req_if.sink    req,
   input  logic       full,
   output logic       push,
   output turns_type  push_data
);

   localparam int SHIFT = TURN_W - ANGLE_FRAC_BITS - 3;
   localparam frac_tab_type FRAC_TAB = frac_table(SHIFT);

   logic                     adv;
   logic signed [DL_W-1:0]   val       [LANES];
   logic [OFS_W-1:0]         ofs_in    [LANES];
   logic [PROD_W-1:0]        prod_in   [LANES];
   logic [OFS_W-1:0]         f1_ofs_ff [LANES];
   logic [PROD_W-1:0]        f1_prod_ff[LANES];
   logic                     f1_vld_ff;
   logic [QUO_W-1:0]         quo       [LANES];
   logic [QUO_W-1:0]         quo_fix   [LANES];
   logic [REM_W-1:0]         rem_raw   [LANES];
   logic [REM_W-1:0]         rem_fix   [LANES];
   logic [TURN_W-1:0]        turn_in   [LANES];
   turns_type                f2_turns_ff;
   turns_type                f2_turns_in;
   logic                     f2_vld_ff;

   // hold everything while the queue is full and a converted item waits
   assign adv       = !(f2_vld_ff && full);
   assign req.ready = adv;
   assign push      = f2_vld_ff && !full;
   assign push_data = f2_turns_ff;

   always_comb begin
      val[0] = DL_W'(req.end_lon) - DL_W'(req.start_lon);
      val[1] = DL_W'(req.start_lat);
      val[2] = DL_W'(req.end_lat);
      for (int l = 0; l < LANES; l++) begin
         ofs_in[l]  = OFS_W'(val[l]) + DIV_OFFSET;
         prod_in[l] = PROD_W'(ofs_in[l]) * PROD_W'(RECIP);
      end
   end

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         quo[l]     = f1_prod_ff[l][PROD_W-1 -: QUO_W];
         rem_raw[l] = f1_ofs_ff[l][REM_W-1:0] - REM_W'(quo[l] * DIV_BASE);
         if (rem_raw[l] >= REM_W'(DIV_BASE)) begin
            quo_fix[l] = quo[l] + QUO_W'(1);
            rem_fix[l] = rem_raw[l] - REM_W'(DIV_BASE);
         end else begin
            quo_fix[l] = quo[l];
            rem_fix[l] = rem_raw[l];
         end
         turn_in[l] = ((TURN_W'(quo_fix[l]) - TURN_W'(QUO_BIAS)) << SHIFT)
                    + FRAC_TAB[rem_fix[l][IDX_W-1:0]];
      end
      f2_turns_in.dlon = turn_in[0];
      f2_turns_in.lat1 = turn_in[1];
      f2_turns_in.lat2 = turn_in[2];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_vld_ff <= 1'b0;
         f2_vld_ff <= 1'b0;
      end else if (adv) begin
         f1_vld_ff <= req.valid;
         f2_vld_ff <= f1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f1_ofs_ff   <= ofs_in;
         f1_prod_ff  <= prod_in;
         f2_turns_ff <= f2_turns_in;
      end
   end

endmodule

// ----- src/gcc_queue.sv -----
// ----------------------------------------------------------------------------
// gcc_queue: short FIFO between the intake and the trigonometry pipeline
// Push is only offered when not full.
// ----------------------------------------------------------------------------
module gcc_queue import gcc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  turns_type push_data,
   output logic      full,
   input  logic      pop,
   output turns_type pop_data,
   output logic      empty
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   turns_type        mem [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   assign full     = (cnt_ff == CNT_W'(QUEUE_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign pop_data = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ----- src/gcc_rotate.sv -----
// ----------------------------------------------------------------------------
// gcc_rotate: pipelined CORDIC sine and cosine of a binary angle
// One fold stage, then one stage per iteration; outputs have 30 fraction bits.
// ----------------------------------------------------------------------------
module gcc_rotate import gcc_pkg::*; #(
   parameter int ITER = TRIG_ITERATIONS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic [TURN_W-1:0]       turn,
   output logic signed [ROT_W-1:0] sin_val,
   output logic signed [ROT_W-1:0] cos_val
);

   logic                    flip_in;
   logic [TURN_W-1:0]       folded;
   logic signed [ROT_W-1:0] z0_in, z0_ff;
   logic                    flip_ff [ITER+1];
   logic signed [ROT_W-1:0] x_ff [ITER];
   logic signed [ROT_W-1:0] y_ff [ITER];
   logic signed [ROT_W-1:0] z_ff [ITER];

   // fold the left half-plane onto the right one
   always_comb begin
      flip_in = turn[TURN_W-1] ^ turn[TURN_W-2];
      folded  = {turn[TURN_W-1] ^ flip_in, turn[TURN_W-2:0]};
      z0_in   = ROT_W'(signed'(folded));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         z0_ff      <= z0_in;
         flip_ff[0] <= flip_in;
      end
   end

   for (genvar i = 0; i < ITER; i++) begin : g_iter
      localparam int K = i % 32;
      logic signed [ROT_W-1:0] xs, ys, zs, x_in, y_in, z_in;

      if (i == 0) begin : g_first
         assign xs = INV_GAIN;
         assign ys = '0;
         assign zs = z0_ff;
      end else begin : g_next
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
      end

      always_comb begin
         if (!zs[ROT_W-1]) begin
            x_in = xs - (ys >>> K);
            y_in = ys + (xs >>> K);
            z_in = zs - signed'(ROT_W'(ATAN_TURN[K]));
         end else begin
            x_in = xs + (ys >>> K);
            y_in = ys - (xs >>> K);
            z_in = zs + signed'(ROT_W'(ATAN_TURN[K]));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]      <= x_in;
            y_ff[i]      <= y_in;
            z_ff[i]      <= z_in;
            flip_ff[i+1] <= flip_ff[i];
         end
      end
   end

   assign sin_val = flip_ff[ITER] ? -y_ff[ITER-1] : y_ff[ITER-1];
   assign cos_val = flip_ff[ITER] ? -x_ff[ITER-1] : x_ff[ITER-1];

endmodule

// ----- src/gcc_vector.sv -----
// ----------------------------------------------------------------------------
// gcc_vector: pipelined CORDIC atan2 giving a binary angle
// One stage to fold negative x and flag the all-zero pair, then one per iteration.
// ----------------------------------------------------------------------------
module gcc_vector import gcc_pkg::*; #(
   parameter int ITER = TRIG_ITERATIONS_DEF
) (
   input  logic                    clock,
   input  logic                    en,
   input  logic signed [VEC_W-1:0] y_val,
   input  logic signed [VEC_W-1:0] x_val,
   output logic [TURN_W-1:0]       turn
);

   logic                    zero_in;
   logic signed [VEC_W-1:0] x0_in, y0_in, x0_ff, y0_ff;
   logic [TURN_W-1:0]       z0_in, z0_ff;
   logic                    zero_ff [ITER+1];
   logic signed [VEC_W-1:0] x_ff [ITER];
   logic signed [VEC_W-1:0] y_ff [ITER];
   logic [TURN_W-1:0]       z_ff [ITER];

   always_comb begin
      zero_in = (x_val == '0) && (y_val == '0);
      if (x_val[VEC_W-1]) begin
         x0_in = -x_val;
         y0_in = -y_val;
         z0_in = TURN_W'(1) << (TURN_W - 1);
      end else begin
         x0_in = x_val;
         y0_in = y_val;
         z0_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x0_ff      <= x0_in;
         y0_ff      <= y0_in;
         z0_ff      <= z0_in;
         zero_ff[0] <= zero_in;
      end
   end

   for (genvar i = 0; i < ITER; i++) begin : g_iter
      localparam int K = i % 32;
      logic signed [VEC_W-1:0] xs, ys, x_in, y_in;
      logic [TURN_W-1:0]       zs, z_in;

      if (i == 0) begin : g_first
         assign xs = x0_ff;
         assign ys = y0_ff;
         assign zs = z0_ff;
      end else begin : g_next
         assign xs = x_ff[i-1];
         assign ys = y_ff[i-1];
         assign zs = z_ff[i-1];
      end

      always_comb begin
         if (!ys[VEC_W-1]) begin
            x_in = xs + (ys >>> K);
            y_in = ys - (xs >>> K);
            z_in = zs + ATAN_TURN[K];
         end else begin
            x_in = xs - (ys >>> K);
            y_in = ys + (xs >>> K);
            z_in = zs - ATAN_TURN[K];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[i]      <= x_in;
            y_ff[i]      <= y_in;
            z_ff[i]      <= z_in;
            zero_ff[i+1] <= zero_ff[i];
         end
      end
   end

   assign turn = zero_ff[ITER] ? '0 : z_ff[ITER-1];

endmodule

// ----- src/gcc_back.sv -----
// ----------------------------------------------------------------------------
// gcc_back: trigonometry pipeline and result register
// Three sine/cosine units, two product stages, two atan2 units, degree output.
// ----------------------------------------------------------------------------
module gcc_back import gcc_pkg::*; #(
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  turns_type head,
   input  logic      empty,
   output logic      pop,
   gcc_rsp_if.source rsp
);

   localparam int LAT    = 2 * TRIG_ITERATIONS + 5;
   localparam int CONV_W = TURN_W + 10;
   localparam logic signed [CONV_W-1:0] DEG_SCALE = CONV_W'(360);
   localparam logic signed [CONV_W-1:0] OUT_ROUND = CONV_W'(1) <<< (31 - ANGLE_FRAC_BITS);
   localparam logic signed [CONV_W-1:0] HALF_TURN = CONV_W'(180) <<< ANGLE_FRAC_BITS;

   logic                       adv;
   logic [LAT-1:0]             vld_ff;
   logic signed [ROT_W-1:0]    sl, cl, s1, c1, s2, c2;
   logic signed [ROT_W-1:0]    a_ff, b_ff, y1_ff, y2_ff, cl_ff;
   logic signed [VEC_W-1:0]    x1_in, x2_in, x1_ff, x2_ff, y1v_ff, y2v_ff;
   logic [TURN_W-1:0]          t1, t2;
   logic signed [COURSE_W-1:0] out1_ff, out2_ff;

   function automatic logic signed [ROT_W-1:0] fmul(input logic signed [ROT_W-1:0] a,
                                                    input logic signed [ROT_W-1:0] b);
      logic signed [2*ROT_W-1:0] p;
      p = a * b;
      return ROT_W'(p >>> UNIT_FRAC);
   endfunction

   function automatic logic signed [COURSE_W-1:0] to_deg(input logic [TURN_W-1:0] t);
      logic signed [CONV_W-1:0] p;
      logic signed [CONV_W-1:0] r;
      p = CONV_W'(signed'(t)) * DEG_SCALE + OUT_ROUND;
      r = p >>> (TURN_W - ANGLE_FRAC_BITS);
      if (r == -HALF_TURN) begin
         r = HALF_TURN;
      end
      return COURSE_W'(r);
   endfunction

   // advance the whole pipeline unless the result register is blocked
   assign adv = !vld_ff[LAT-1] || rsp.ready;
   assign pop = adv && !empty;

   gcc_rotate #(.ITER(TRIG_ITERATIONS)) u_rot_dl (
      .clock(clock), .en(adv), .turn(head.dlon), .sin_val(sl), .cos_val(cl));
   gcc_rotate #(.ITER(TRIG_ITERATIONS)) u_rot_p1 (
      .clock(clock), .en(adv), .turn(head.lat1), .sin_val(s1), .cos_val(c1));
   gcc_rotate #(.ITER(TRIG_ITERATIONS)) u_rot_p2 (
      .clock(clock), .en(adv), .turn(head.lat2), .sin_val(s2), .cos_val(c2));

   always_ff @(posedge clock) begin
      if (adv) begin
         a_ff  <= fmul(c1, s2);
         b_ff  <= fmul(s1, c2);
         y1_ff <= fmul(c2, sl);
         y2_ff <= fmul(c1, sl);
         cl_ff <= cl;
      end
   end

   always_comb begin
      x1_in = VEC_W'(a_ff) - VEC_W'(fmul(b_ff, cl_ff));
      x2_in = VEC_W'(fmul(a_ff, cl_ff)) - VEC_W'(b_ff);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x1_ff  <= x1_in;
         x2_ff  <= x2_in;
         y1v_ff <= VEC_W'(y1_ff);
         y2v_ff <= VEC_W'(y2_ff);
      end
   end

   gcc_vector #(.ITER(TRIG_ITERATIONS)) u_vec_start (
      .clock(clock), .en(adv), .y_val(y1v_ff), .x_val(x1_ff), .turn(t1));
   gcc_vector #(.ITER(TRIG_ITERATIONS)) u_vec_end (
      .clock(clock), .en(adv), .y_val(y2v_ff), .x_val(x2_ff), .turn(t2));

   always_ff @(posedge clock) begin
      if (adv) begin
         out1_ff <= to_deg(t1);
         out2_ff <= to_deg(t2);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[LAT-2:0], pop};
      end
   end

   assign rsp.valid           = vld_ff[LAT-1];
   assign rsp.course_at_start = out1_ff;
   assign rsp.course_at_end   = out2_ff;

endmodule
